// ===== rtl/tsn_pkg.sv =====
// Shared types, constants and the square-root step of the torus normal pipeline.
// No dependencies; imported by every module of the block.
package tsn_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X     = 3'd0,
    CFG_CENTER_Y     = 3'd1,
    CFG_CENTER_Z     = 3'd2,
    CFG_AXIS_X       = 3'd3,
    CFG_AXIS_Y       = 3'd4,
    CFG_AXIS_Z       = 3'd5,
    CFG_MAJOR_RADIUS = 3'd6
  } cfg_reg_e;

  // Field widths and reset values.
  localparam int AXIS_W    = 16;
  localparam int AXIS_FRAC = 14;
  localparam int RADIUS_W  = 31;
  localparam int NORMAL_W  = 16;
  localparam logic signed [AXIS_W-1:0] AXIS_ONE     = 16'sd16384;
  localparam logic [RADIUS_W-1:0]      RADIUS_RESET = 31'd131072;

  // Offset magnitudes are kept below 2^40 before the dot product.
  localparam int WIDE_LIMIT = 40;

  // Block normalisation puts the largest magnitude in [2^29, 2^30).
  localparam int NORM_MSB = 29;
  localparam int NORM_W   = 31;
  localparam int MAG_W    = 31;
  localparam int LEN_W    = 31;

  // Integer square root of a sum of three squares below 2^62.
  localparam int SQ_W        = 62;
  localparam int SQRT_STEPS  = 31;
  localparam int SQRT_TOP    = 60;

  typedef struct packed {
    logic [SQ_W-1:0] n;
    logic [SQ_W-1:0] r;
  } sqrt_t;

  // One digit of the bitwise integer square root.
  function automatic sqrt_t sqrt_step(sqrt_t s, logic [SQ_W-1:0] bit_v);
    sqrt_t         o;
    logic [SQ_W:0] trial;
    trial = {1'b0, s.r} + {1'b0, bit_v};
    if ({1'b0, s.n} >= trial) begin
      o.n = s.n - SQ_W'(trial);
      o.r = (s.r >> 1) + bit_v;
    end else begin
      o.n = s.n;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

endpackage

// ===== rtl/tsn_vec_div.sv =====
// Scales a three-component vector by mult / |vector| with rounding, fully pipelined.
// Depends on tsn_pkg for the normalisation constants and the square-root step.
module tsn_vec_div #(
  parameter int VW = 40,
  parameter int MW = 31,
  parameter int QW = 33,
  parameter int SW = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [VW-1:0] vec_i [3],
  input  logic [MW-1:0]        mult_i,
  input  logic [SW-1:0]        side_i,
  output logic                 valid_o,
  output logic signed [QW:0]   quot_o [3],
  output logic                 zero_o,
  output logic [SW-1:0]        side_o
);
  import tsn_pkg::*;

  localparam int PW  = $clog2(VW);
  localparam int EW  = (VW > NORM_W) ? VW : NORM_W;
  localparam int PRW = MAG_W + MW;
  localparam int NW  = PRW + 1;
  localparam int RW  = LEN_W + 1;

  // Stage A: bitwise OR of magnitudes has the same leading one as the maximum.
  logic [VW-1:0]        mag_or;
  logic signed [VW-1:0] a_vec_q [3];
  logic [MW-1:0]        a_mult_q;
  logic [SW-1:0]        a_side_q;
  logic [VW-1:0]        a_or_q;
  logic                 a_valid_q;

  always_comb begin
    mag_or = '0;
    for (int i = 0; i < 3; i++) begin
      mag_or = mag_or | (vec_i[i][VW-1] ? VW'(-vec_i[i]) : VW'(vec_i[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_vec_q  <= vec_i;
      a_mult_q <= mult_i;
      a_side_q <= side_i;
      a_or_q   <= mag_or;
    end
  end

  // Stage B: leading-one position gives the shift direction and amount.
  logic [PW-1:0]        lead;
  logic signed [VW-1:0] b_vec_q [3];
  logic [MW-1:0]        b_mult_q;
  logic [SW-1:0]        b_side_q;
  logic                 b_right_q;
  logic [PW-1:0]        b_sh_q;
  logic                 b_zero_q;
  logic                 b_valid_q;

  always_comb begin
    lead = '0;
    for (int b = 0; b < VW; b++) begin
      if (a_or_q[b]) lead = PW'(b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_vec_q   <= a_vec_q;
      b_mult_q  <= a_mult_q;
      b_side_q  <= a_side_q;
      b_right_q <= int'(lead) > NORM_MSB;
      b_sh_q    <= (int'(lead) > NORM_MSB) ? PW'(int'(lead) - NORM_MSB)
                                           : PW'(NORM_MSB - int'(lead));
      b_zero_q  <= (a_or_q == '0);
    end
  end

  // Stage C: apply the shift; right shifts round toward minus infinity.
  logic signed [EW-1:0]     ext [3];
  logic signed [EW-1:0]     shifted [3];
  logic signed [NORM_W-1:0] c_n_q [3];
  logic [MW-1:0]            c_mult_q;
  logic [SW-1:0]            c_side_q;
  logic                     c_zero_q;
  logic                     c_valid_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ext[i]     = EW'(b_vec_q[i]);
      shifted[i] = b_right_q ? (ext[i] >>> b_sh_q) : (ext[i] << b_sh_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) c_n_q[i] <= NORM_W'(shifted[i]);
      c_mult_q <= b_mult_q;
      c_side_q <= b_side_q;
      c_zero_q <= b_zero_q;
    end
  end

  // Stage D: squares for the length and products for the numerators.
  logic [MAG_W-1:0] c_mag [3];
  logic [SQ_W-1:0]  m_sq_q [3];
  logic [PRW-1:0]   m_prod_q [3];
  logic [2:0]       m_neg_q;
  logic [SW-1:0]    m_side_q;
  logic             m_zero_q;
  logic             m_valid_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_mag[i] = c_n_q[i][NORM_W-1] ? MAG_W'(-c_n_q[i]) : MAG_W'(c_n_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        m_sq_q[i]   <= SQ_W'(c_mag[i]) * SQ_W'(c_mag[i]);
        m_prod_q[i] <= PRW'(c_mag[i]) * PRW'(c_mult_q);
        m_neg_q[i]  <= c_n_q[i][NORM_W-1];
      end
      m_side_q <= c_side_q;
      m_zero_q <= c_zero_q;
    end
  end

  // Square-root pipeline, one result bit per stage; entry 0 holds the sum.
  sqrt_t          sq_q      [SQRT_STEPS+1];
  logic [PRW-1:0] sq_prod_q [SQRT_STEPS+1][3];
  logic [2:0]     sq_neg_q  [SQRT_STEPS+1];
  logic [SW-1:0]  sq_side_q [SQRT_STEPS+1];
  logic           sq_zero_q [SQRT_STEPS+1];
  logic           sq_valid_q[SQRT_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q[0].n    <= m_sq_q[0] + m_sq_q[1] + m_sq_q[2];
      sq_q[0].r    <= '0;
      sq_prod_q[0] <= m_prod_q;
      sq_neg_q[0]  <= m_neg_q;
      sq_side_q[0] <= m_side_q;
      sq_zero_q[0] <= m_zero_q;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    sqrt_t nxt;
    assign nxt = sqrt_step(sq_q[k], SQ_W'(1) << (SQRT_TOP - 2 * k));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[k+1]      <= nxt;
        sq_prod_q[k+1] <= sq_prod_q[k];
        sq_neg_q[k+1]  <= sq_neg_q[k];
        sq_side_q[k+1] <= sq_side_q[k];
        sq_zero_q[k+1] <= sq_zero_q[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_valid_q[k+1] <= 1'b0;
      end else if (en_i) begin
        sq_valid_q[k+1] <= sq_valid_q[k];
      end
    end
  end

  // Divider entry: numerator gets half the length for round-to-nearest.
  logic [LEN_W-1:0] len;
  logic [NW-1:0]    num_init [3];

  assign len = sq_q[SQRT_STEPS].r[LEN_W-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_init[i] = NW'(sq_prod_q[SQRT_STEPS][i]) + NW'(len >> 1);
    end
  end

  logic [RW-1:0]    dv_rem_q  [QW+1][3];
  logic [NW-1:0]    dv_num_q  [QW+1][3];
  logic [QW-1:0]    dv_quo_q  [QW+1][3];
  logic [LEN_W-1:0] dv_len_q  [QW+1];
  logic [2:0]       dv_neg_q  [QW+1];
  logic [SW-1:0]    dv_side_q [QW+1];
  logic             dv_zero_q [QW+1];
  logic             dv_valid_q[QW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_q[0][i] <= RW'(num_init[i] >> QW);
        dv_num_q[0][i] <= num_init[i];
        dv_quo_q[0][i] <= '0;
      end
      dv_len_q[0]  <= len;
      dv_neg_q[0]  <= sq_neg_q[SQRT_STEPS];
      dv_side_q[0] <= sq_side_q[SQRT_STEPS];
      dv_zero_q[0] <= sq_zero_q[SQRT_STEPS];
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [RW-1:0] sh   [3];
    logic          ge   [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        sh[i] = {dv_rem_q[j][i][RW-2:0], dv_num_q[j][i][QW-1-j]};
        ge[i] = sh[i] >= RW'(dv_len_q[j]);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem_q[j+1][i] <= ge[i] ? sh[i] - RW'(dv_len_q[j]) : sh[i];
          dv_num_q[j+1][i] <= dv_num_q[j][i];
          dv_quo_q[j+1][i] <= {dv_quo_q[j][i][QW-2:0], ge[i]};
        end
        dv_len_q[j+1]  <= dv_len_q[j];
        dv_neg_q[j+1]  <= dv_neg_q[j];
        dv_side_q[j+1] <= dv_side_q[j];
        dv_zero_q[j+1] <= dv_zero_q[j];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_valid_q[j+1] <= 1'b0;
      end else if (en_i) begin
        dv_valid_q[j+1] <= dv_valid_q[j];
      end
    end
  end

  // Valid bits of the front stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q     <= 1'b0;
      b_valid_q     <= 1'b0;
      c_valid_q     <= 1'b0;
      m_valid_q     <= 1'b0;
      sq_valid_q[0] <= 1'b0;
      dv_valid_q[0] <= 1'b0;
    end else if (en_i) begin
      a_valid_q     <= valid_i;
      b_valid_q     <= a_valid_q;
      c_valid_q     <= b_valid_q;
      m_valid_q     <= c_valid_q;
      sq_valid_q[0] <= m_valid_q;
      dv_valid_q[0] <= sq_valid_q[SQRT_STEPS];
    end
  end

  // Restore the signs.
  logic signed [QW:0] q_pos [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_pos[i]  = $signed({1'b0, dv_quo_q[QW][i]});
      quot_o[i] = dv_neg_q[QW][i] ? -q_pos[i] : q_pos[i];
    end
  end

  assign valid_o = dv_valid_q[QW];
  assign zero_o  = dv_zero_q[QW];
  assign side_o  = dv_side_q[QW];

endmodule

// ===== rtl/torus_surface_normal_top.sv =====
// Torus surface normal: top level with configuration registers and the offset pipeline.
// Depends on tsn_pkg and instantiates tsn_vec_div twice.
//
// Takes a hit point on a torus and returns its unit surface normal in Q1.15. The pipeline
// accepts one request per clock while the output is not held off; its depth is set by the
// two square-root chains of 31 stages and the two restoring dividers of 33 and 17 stages,
// each one bit per stage. When the output is held off, the whole pipeline freezes and
// in_ready_o drops; nothing is lost or repeated.
// A hit on the axis, or on the tube centre circle, gives degenerate_o high and a zero normal.
// Configuration writes are always taken and should be made only while the block is idle.
module torus_surface_normal_top #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tsn_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [((COORD_WIDTH > 31) ? COORD_WIDTH : 31)-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] hit_x_i,
  input  logic signed [COORD_WIDTH-1:0] hit_y_i,
  input  logic signed [COORD_WIDTH-1:0] hit_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [tsn_pkg::NORMAL_W-1:0] normal_x_o,
  output logic signed [tsn_pkg::NORMAL_W-1:0] normal_y_o,
  output logic signed [tsn_pkg::NORMAL_W-1:0] normal_z_o,
  output logic                          degenerate_o
);
  import tsn_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int AW   = CW + 1;
  localparam int A2W  = (AW > WIDE_LIMIT + 1) ? WIDE_LIMIT + 1 : AW;
  localparam int SAW  = $clog2(AW);
  localparam int PW2  = A2W + AXIS_W;
  localparam int SUMW = PW2 + 2;
  localparam int YW   = SUMW - AXIS_FRAC;
  localparam int BW   = YW + AXIS_W;
  localparam int DW   = BW - AXIS_FRAC + 1;
  localparam int Q1W  = 33;
  localparam int X1W  = Q1W + 1;
  localparam int VW2  = ((A2W > X1W) ? A2W : X1W) + 1;
  localparam int Q2W  = 17;
  localparam int N2W  = Q2W + 1;
  localparam int MW2  = 16;

  // Pipeline advances whenever the output register is free or being emptied.
  logic en;
  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  logic signed [CW-1:0]     center_q [3];
  logic signed [AXIS_W-1:0] axis_q   [3];
  logic [RADIUS_W-1:0]      radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= '{default: '0};
      axis_q   <= '{'0, '0, AXIS_ONE};
      radius_q <= RADIUS_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_CENTER_X:     center_q[0] <= CW'(cfg_data_i);
        CFG_CENTER_Y:     center_q[1] <= CW'(cfg_data_i);
        CFG_CENTER_Z:     center_q[2] <= CW'(cfg_data_i);
        CFG_AXIS_X:       axis_q[0]   <= AXIS_W'(cfg_data_i);
        CFG_AXIS_Y:       axis_q[1]   <= AXIS_W'(cfg_data_i);
        CFG_AXIS_Z:       axis_q[2]   <= AXIS_W'(cfg_data_i);
        CFG_MAJOR_RADIUS: radius_q    <= RADIUS_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Stage 0: offset from the centre, exact.
  logic signed [CW-1:0] hit [3];
  logic signed [AW-1:0] s0_a_q [3];
  logic                 s0_valid_q;

  assign hit[0] = hit_x_i;
  assign hit[1] = hit_y_i;
  assign hit[2] = hit_z_i;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) s0_a_q[i] <= AW'(hit[i]) - AW'(center_q[i]);
    end
  end

  // Stage 1: halve offset and radius together while the offset is too wide.
  logic [AW-1:0]         a_or;
  logic [SAW-1:0]        a_lead;
  logic [SAW-1:0]        sa;
  logic signed [A2W-1:0] s1_a_q [3];
  logic [RADIUS_W-1:0]   s1_r_q;
  logic                  s1_valid_q;

  always_comb begin
    a_or = '0;
    for (int i = 0; i < 3; i++) begin
      a_or = a_or | (s0_a_q[i][AW-1] ? AW'(-s0_a_q[i]) : AW'(s0_a_q[i]));
    end
    a_lead = '0;
    for (int b = 0; b < AW; b++) begin
      if (a_or[b]) a_lead = SAW'(b);
    end
    sa = (int'(a_lead) >= WIDE_LIMIT) ? SAW'(int'(a_lead) - WIDE_LIMIT + 1) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) s1_a_q[i] <= A2W'(s0_a_q[i] >>> sa);
      s1_r_q <= radius_q >> sa;
    end
  end

  // Stage 2: products with the axis.
  logic signed [PW2-1:0] s2_p_q [3];
  logic signed [A2W-1:0] s2_a_q [3];
  logic [RADIUS_W-1:0]   s2_r_q;
  logic                  s2_valid_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) s2_p_q[i] <= PW2'(s1_a_q[i]) * PW2'(axis_q[i]);
      s2_a_q <= s1_a_q;
      s2_r_q <= s1_r_q;
    end
  end

  // Stage 3: dot product, scaled back by the axis fraction.
  logic signed [SUMW-1:0] dot;
  logic signed [YW-1:0]   s3_y_q;
  logic signed [A2W-1:0]  s3_a_q [3];
  logic [RADIUS_W-1:0]    s3_r_q;
  logic                   s3_valid_q;

  assign dot = SUMW'(s2_p_q[0]) + SUMW'(s2_p_q[1]) + SUMW'(s2_p_q[2]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_y_q <= YW'(dot >>> AXIS_FRAC);
      s3_a_q <= s2_a_q;
      s3_r_q <= s2_r_q;
    end
  end

  // Stage 4: axial component.
  logic signed [BW-1:0]  s4_b_q [3];
  logic signed [A2W-1:0] s4_a_q [3];
  logic [RADIUS_W-1:0]   s4_r_q;
  logic                  s4_valid_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) s4_b_q[i] <= BW'(axis_q[i]) * BW'(s3_y_q);
      s4_a_q <= s3_a_q;
      s4_r_q <= s3_r_q;
    end
  end

  // Stage 5: radial vector.
  logic signed [DW-1:0]  s5_d_q [3];
  logic signed [A2W-1:0] s5_a_q [3];
  logic [RADIUS_W-1:0]   s5_r_q;
  logic                  s5_valid_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s5_d_q[i] <= DW'(s4_a_q[i]) - DW'(s4_b_q[i] >>> AXIS_FRAC);
      end
      s5_a_q <= s4_a_q;
      s5_r_q <= s4_r_q;
    end
  end

  // Tube-centre point: radius times the radial direction.
  logic                  x_valid;
  logic signed [X1W-1:0] x_vec [3];
  logic                  x_zero;
  logic [3*A2W-1:0]      x_side;
  logic signed [A2W-1:0] x_a [3];

  tsn_vec_div #(
    .VW (DW),
    .MW (RADIUS_W),
    .QW (Q1W),
    .SW (3 * A2W)
  ) u_radial (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s5_valid_q),
    .vec_i   (s5_d_q),
    .mult_i  (s5_r_q),
    .side_i  ({s5_a_q[2], s5_a_q[1], s5_a_q[0]}),
    .valid_o (x_valid),
    .quot_o  (x_vec),
    .zero_o  (x_zero),
    .side_o  (x_side)
  );

  assign x_a[0] = x_side[A2W-1:0];
  assign x_a[1] = x_side[2*A2W-1:A2W];
  assign x_a[2] = x_side[3*A2W-1:2*A2W];

  // Stage 6: vector from the tube centre to the hit.
  logic signed [VW2-1:0] s6_v_q [3];
  logic                  s6_zero_q;
  logic                  s6_valid_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) s6_v_q[i] <= VW2'(x_a[i]) - VW2'(x_vec[i]);
      s6_zero_q <= x_zero;
    end
  end

  // Final normalisation to Q1.15.
  logic                  n_valid;
  logic signed [N2W-1:0] n_vec [3];
  logic                  n_zero;
  logic                  n_axis_zero;

  tsn_vec_div #(
    .VW (VW2),
    .MW (MW2),
    .QW (Q2W),
    .SW (1)
  ) u_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s6_valid_q),
    .vec_i   (s6_v_q),
    .mult_i  (MW2'(1) << (MW2 - 1)),
    .side_i  (s6_zero_q),
    .valid_o (n_valid),
    .quot_o  (n_vec),
    .zero_o  (n_zero),
    .side_o  (n_axis_zero)
  );

  // Saturation and the degenerate override.
  logic                       degen;
  logic signed [NORMAL_W-1:0] sat [3];

  assign degen = n_zero || n_axis_zero;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (n_vec[i] > N2W'(32767)) begin
        sat[i] = 16'sd32767;
      end else if (n_vec[i] < -N2W'(32768)) begin
        sat[i] = -16'sd32768;
      end else begin
        sat[i] = NORMAL_W'(n_vec[i]);
      end
    end
  end

  // Output register.
  logic                       out_valid_q;
  logic signed [NORMAL_W-1:0] normal_q [3];
  logic                       degen_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) normal_q[i] <= degen ? '0 : sat[i];
      degen_q <= degen;
    end
  end

  // Valid bits of the local stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      s6_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q  <= in_valid_i;
      s1_valid_q  <= s0_valid_q;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      s5_valid_q  <= s4_valid_q;
      s6_valid_q  <= x_valid;
      out_valid_q <= n_valid;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign normal_x_o   = normal_q[0];
  assign normal_y_o   = normal_q[1];
  assign normal_z_o   = normal_q[2];
  assign degenerate_o = degen_q;

endmodule

// ===== rtl/tsn_checker.sv =====
// Port-level checks of the torus normal block, attached by the bind below.
// Depends on tsn_pkg for the normal width.
module tsn_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic signed [tsn_pkg::NORMAL_W-1:0] normal_x_o,
  input logic signed [tsn_pkg::NORMAL_W-1:0] normal_y_o,
  input logic signed [tsn_pkg::NORMAL_W-1:0] normal_z_o,
  input logic                          degenerate_o
);
  import tsn_pkg::*;

  // A waiting result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before it was taken");

  // A waiting result keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(normal_x_o) && $stable(normal_y_o)
                                    && $stable(normal_z_o) && $stable(degenerate_o))
    else $error("waiting result changed");

  // A degenerate result carries a zero normal.
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> normal_x_o == '0 && normal_y_o == '0
                                    && normal_z_o == '0)
    else $error("degenerate result with a nonzero normal");

  // With no result pending the pipeline must be taking requests.
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with an empty output");

  // Nothing emerges in the cycle right after reset.
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result present straight after reset");

endmodule

bind torus_surface_normal_top tsn_checker u_tsn_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .normal_x_o   (normal_x_o),
  .normal_y_o   (normal_y_o),
  .normal_z_o   (normal_z_o),
  .degenerate_o (degenerate_o)
);
